/* sv/fdr_pkg.sv */
// shared types and constants for the frame deframer
package fdr_pkg;

   // operation codes of an input transfer
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POLL = 1'b1;

   // configuration register indexes
   localparam logic CSR_SYNC_FIRST  = 1'b0;
   localparam logic CSR_SYNC_SECOND = 1'b1;

   // reset values of the sync registers
   localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

   // header plus checksum, the smallest frame
   localparam int MIN_FRAME = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_HDR0,
      ST_HDR1,
      ST_LEN,
      ST_DEV,
      ST_CMD,
      ST_SUM,
      ST_EMIT,
      ST_NOFRAME
   } state_type;

   // ring read address, relative to the read pointer or to the last read
   typedef enum logic [2:0] {
      OFF_ZERO,
      OFF_ONE,
      OFF_TWO,
      OFF_THREE,
      OFF_FOUR,
      OFF_FIVE,
      OFF_NEXT
   } off_sel_type;

   typedef struct packed {
      logic        push;
      logic        poll_start;
      logic        rd_en;
      off_sel_type off_sel;
      logic        drop;
      logic        ld_len;
      logic        ld_dev;
      logic        ld_cmd;
      logic        sum_acc;
      logic        idx_clr;
      logic        idx_inc;
      logic        out_frame;
      logic        out_none;
      logic        consume;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_lt_min;
      logic hdr0_ok;
      logic hdr1_ok;
      logic len_over;
      logic count_short;
      logic idx_at_len;
      logic sum_ok;
      logic emit_last;
      logic out_free;
   } ctrl_status_type;

endpackage

/* sv/fdr_ram.sv */
// generic single write, single read ram with registered read data
module fdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/fdr_ctrl.sv */
// sequencer for push and frame scan of the deframer
module fdr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_operation,
   output logic                     req_ready,
   output fdr_pkg::ctrl_cmd_type    cmd,
   input  fdr_pkg::ctrl_status_type status
);
   import fdr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_operation == OP_POLL) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.count_lt_min ? ST_NOFRAME : ST_HDR0;
         end
         ST_HDR0: begin
            state_in = status.hdr0_ok ? ST_HDR1 : ST_CHECK;
         end
         ST_HDR1: begin
            state_in = status.hdr1_ok ? ST_LEN : ST_CHECK;
         end
         ST_LEN: begin
            if (status.len_over) state_in = ST_CHECK;
            else if (status.count_short) state_in = ST_NOFRAME;
            else state_in = ST_DEV;
         end
         ST_DEV:  state_in = ST_CMD;
         ST_CMD:  state_in = ST_SUM;
         ST_SUM: begin
            if (status.idx_at_len) state_in = status.sum_ok ? ST_EMIT : ST_CHECK;
         end
         ST_EMIT: begin
            if (status.out_free && status.emit_last) state_in = ST_IDLE;
         end
         ST_NOFRAME: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.off_sel = OFF_ZERO;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.push       = req_valid && req_operation == OP_PUSH;
            cmd.poll_start = req_valid && req_operation == OP_POLL;
         end
         ST_CHECK: begin
            cmd.rd_en   = !status.count_lt_min;
            cmd.off_sel = OFF_ZERO;
         end
         ST_HDR0: begin
            cmd.drop    = !status.hdr0_ok;
            cmd.rd_en   = status.hdr0_ok;
            cmd.off_sel = OFF_ONE;
         end
         ST_HDR1: begin
            cmd.drop    = !status.hdr1_ok;
            cmd.rd_en   = status.hdr1_ok;
            cmd.off_sel = OFF_FOUR;
         end
         ST_LEN: begin
            cmd.drop    = status.len_over;
            cmd.ld_len  = !status.len_over;
            cmd.rd_en   = !status.len_over && !status.count_short;
            cmd.off_sel = OFF_TWO;
         end
         ST_DEV: begin
            cmd.ld_dev  = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.off_sel = OFF_THREE;
         end
         ST_CMD: begin
            cmd.ld_cmd  = 1'b1;
            cmd.idx_clr = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.off_sel = OFF_FIVE;
         end
         ST_SUM: begin
            if (status.idx_at_len) begin
               cmd.drop    = !status.sum_ok;
               cmd.idx_clr = status.sum_ok;
               cmd.rd_en   = status.sum_ok;
               cmd.off_sel = OFF_FIVE;
            end else begin
               cmd.sum_acc = 1'b1;
               cmd.idx_inc = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.off_sel = OFF_NEXT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_frame = 1'b1;
               cmd.consume   = status.emit_last;
               cmd.idx_inc   = !status.emit_last;
               cmd.rd_en     = !status.emit_last;
               cmd.off_sel   = OFF_NEXT;
            end
         end
         ST_NOFRAME: begin
            cmd.out_none = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* sv/fdr_datapath.sv */
// ring pointers, header checks, checksum and result register of the deframer
module fdr_datapath #(
   parameter int RING_DEPTH  = 256,
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [7:0]               csr_wdata,
   input  logic [7:0]               req_rx_byte,
   input  fdr_pkg::ctrl_cmd_type    cmd,
   output fdr_pkg::ctrl_status_type status,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_found,
   output logic [7:0]               rsp_device_id,
   output logic [7:0]               rsp_command_id,
   output logic [5:0]               rsp_payload_length,
   output logic [7:0]               rsp_payload_byte,
   output logic [4:0]               rsp_byte_index,
   output logic                     rsp_last,
   output logic                     rsp_overflow_seen
);
   import fdr_pkg::*;

   localparam int PW = $clog2(RING_DEPTH);
   localparam int LW = $clog2(MAX_PAYLOAD + 1);
   localparam int CW = PW + 8;
   localparam logic [PW:0] DEPTH_EXT = (PW + 1)'(RING_DEPTH);

   function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                              input logic [PW:0]   step);
      logic [PW:0] s;
      s = {1'b0, base} + step;
      if (s >= DEPTH_EXT) s = s - DEPTH_EXT;
      return s[PW-1:0];
   endfunction

   logic [7:0]    sync_first_ff, sync_second_ff;
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff, cur_ff;
   logic          ovf_flag_ff, ovf_seen_ff;
   logic [LW-1:0] len_ff, idx_ff;
   logic [7:0]    dev_ff, cmd_ff, sum_ff;

   logic          rsp_valid_ff;
   logic          found_ff, last_ff;
   logic [7:0]    dev_out_ff, cmd_out_ff, byte_out_ff;
   logic [5:0]    len_out_ff;
   logic [4:0]    idx_out_ff;
   logic          ovf_out_ff;

   logic [PW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [PW:0]   diff;
   logic [PW-1:0] count;
   logic          full;
   logic          ram_we;
   logic          load_out;
   logic [7:0]    len8, idx8;

   // buffered bytes, at most depth minus one
   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff) diff = {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff};
      else diff = {1'b0, wr_ptr_ff} + DEPTH_EXT - {1'b0, rd_ptr_ff};
   end
   assign count = diff[PW-1:0];
   assign full  = wrap_add(wr_ptr_ff, (PW + 1)'(1)) == rd_ptr_ff;

   always_comb begin
      case (cmd.off_sel)
         OFF_ZERO:  rd_addr = rd_ptr_ff;
         OFF_ONE:   rd_addr = wrap_add(rd_ptr_ff, (PW + 1)'(1));
         OFF_TWO:   rd_addr = wrap_add(rd_ptr_ff, (PW + 1)'(2));
         OFF_THREE: rd_addr = wrap_add(rd_ptr_ff, (PW + 1)'(3));
         OFF_FOUR:  rd_addr = wrap_add(rd_ptr_ff, (PW + 1)'(4));
         OFF_FIVE:  rd_addr = wrap_add(rd_ptr_ff, (PW + 1)'(MIN_FRAME - 1));
         OFF_NEXT:  rd_addr = wrap_add(cur_ff, (PW + 1)'(1));
         default:   rd_addr = rd_ptr_ff;
      endcase
   end

   assign ram_we = cmd.push && !full;

   fdr_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign len8 = 8'(len_ff);
   assign idx8 = 8'(idx_ff);

   // checks on the byte just read, the fill count, the index and the output slot
   always_comb begin
      status.count_lt_min = count < PW'(MIN_FRAME);
      status.hdr0_ok      = rd_data == sync_first_ff;
      status.hdr1_ok      = rd_data == sync_second_ff;
      status.len_over     = rd_data > 8'(MAX_PAYLOAD);
      status.count_short  = CW'(count) < (CW'(rd_data) + CW'(MIN_FRAME));
      status.idx_at_len   = idx_ff == len_ff;
      status.sum_ok       = sum_ff == rd_data;
      status.emit_last    = (len_ff == '0) || (idx_ff == len_ff - LW'(1));
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   assign load_out = cmd.out_frame || cmd.out_none;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         ovf_flag_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
               CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (ram_we) wr_ptr_ff <= wrap_add(wr_ptr_ff, (PW + 1)'(1));
         if (cmd.push && full) ovf_flag_ff <= 1'b1;
         else if (cmd.poll_start) ovf_flag_ff <= 1'b0;
         if (cmd.drop) begin
            rd_ptr_ff <= wrap_add(rd_ptr_ff, (PW + 1)'(1));
         end else if (cmd.consume) begin
            rd_ptr_ff <= wrap_add(rd_ptr_ff, (PW + 1)'(len_ff) + (PW + 1)'(MIN_FRAME));
         end
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // frame working registers
   always_ff @(posedge clock) begin
      if (cmd.rd_en) cur_ff <= rd_addr;
      if (cmd.poll_start) ovf_seen_ff <= ovf_flag_ff;
      if (cmd.ld_len) len_ff <= LW'(rd_data);
      if (cmd.ld_dev) begin
         dev_ff <= rd_data;
         sum_ff <= rd_data;
      end else if (cmd.ld_cmd) begin
         sum_ff <= sum_ff + rd_data + len8;
      end else if (cmd.sum_acc) begin
         sum_ff <= sum_ff + rd_data;
      end
      if (cmd.ld_cmd) cmd_ff <= rd_data;
      if (cmd.idx_clr) idx_ff <= '0;
      else if (cmd.idx_inc) idx_ff <= idx_ff + LW'(1);
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_frame) begin
         found_ff    <= 1'b1;
         dev_out_ff  <= dev_ff;
         cmd_out_ff  <= cmd_ff;
         len_out_ff  <= len8[5:0];
         byte_out_ff <= (len_ff == '0) ? 8'h00 : rd_data;
         idx_out_ff  <= idx8[4:0];
         last_ff     <= status.emit_last;
         ovf_out_ff  <= ovf_seen_ff;
      end else if (cmd.out_none) begin
         found_ff    <= 1'b0;
         dev_out_ff  <= 8'h00;
         cmd_out_ff  <= 8'h00;
         len_out_ff  <= 6'd0;
         byte_out_ff <= 8'h00;
         idx_out_ff  <= 5'd0;
         last_ff     <= 1'b1;
         ovf_out_ff  <= ovf_seen_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_device_id      = dev_out_ff;
   assign rsp_command_id     = cmd_out_ff;
   assign rsp_payload_length = len_out_ff;
   assign rsp_payload_byte   = byte_out_ff;
   assign rsp_byte_index     = idx_out_ff;
   assign rsp_last           = last_ff;
   assign rsp_overflow_seen  = ovf_out_ff;

   a_wr_ptr_only_on_push: assert property (@(posedge clock) disable iff (reset)
      !cmd.push |=> $stable(wr_ptr_ff))
      else $error("write pointer moved without a push");

   a_push_not_empty: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> wr_ptr_ff != rd_ptr_ff)
      else $error("ring empty right after a stored push");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");

   a_no_drop_with_consume: assert property (@(posedge clock) disable iff (reset)
      !(cmd.drop && cmd.consume))
      else $error("drop and consume in one cycle");

endmodule

/* sv/frame_deframer_sum8_resync.sv */
// top level of the sync-header frame deframer with 8-bit additive checksum
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_operation, req_rx_byte
//   rsp_      out        rsp_valid / rsp_ready  found, ids, length, byte, index, last, overflow
//   csr_      in         csr_we                 csr_index, csr_wdata
//
// a push is taken in the idle state; a poll drops a byte and rescans on a bad first sync byte,
// a bad second sync byte, an oversize length or a bad checksum
// a good frame gives one result per payload byte (one if empty); no frame gives one result
// synchronous active high reset; the ring contents are not cleared, no clearing pass
// the last result of a poll waits in the output register while pushes are taken
// a stalled rsp_ready holds the scan in the emit or no-frame state; nothing is lost
module frame_deframer_sum8_resync #(
   parameter int RING_DEPTH  = 256,
   parameter int MAX_PAYLOAD = 32
) (
   input  logic       clock,
   input  logic       reset,
   // configuration writes
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   // input items
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_rx_byte,
   // result items
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [7:0] rsp_device_id,
   output logic [7:0] rsp_command_id,
   output logic [5:0] rsp_payload_length,
   output logic [7:0] rsp_payload_byte,
   output logic [4:0] rsp_byte_index,
   output logic       rsp_last,
   output logic       rsp_overflow_seen
);
   import fdr_pkg::*;

   // command and status between sequencer and datapath
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: accepts a transfer only when idle, walks header, sum and emit
   fdr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .cmd           (cmd),
      .status        (status)
   );

   // datapath: ring, pointers, sync compare, checksum, result register
   fdr_datapath #(
      .RING_DEPTH  (RING_DEPTH),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_rx_byte        (req_rx_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_found          (rsp_found),
      .rsp_device_id      (rsp_device_id),
      .rsp_command_id     (rsp_command_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last           (rsp_last),
      .rsp_overflow_seen  (rsp_overflow_seen)
   );

   // a poll transfer never lands while a frame scan is running
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en || cmd.drop) |-> !req_ready)
      else $error("input ready during a scan");

   // a push never overlaps a result load
   a_push_no_result: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !(cmd.out_frame || cmd.out_none))
      else $error("push and result load in one cycle");

   // every consumed frame ends in a valid final result
   a_consume_is_last: assert property (@(posedge clock) disable iff (reset)
      cmd.consume |=> (rsp_valid && rsp_last))
      else $error("frame consumed without a final result");

endmodule
